FILE: hdl/efr_pkg.sv
package efr_pkg;

   // payload buffer depth
   localparam int MAX_PAYLOAD = 11;

   // count runs 0..MAX_PAYLOAD, index runs 0..MAX_PAYLOAD-1
   localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
   localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // fixed result field widths
   localparam int BYTE_W = 8;
   localparam int POS_W  = 4;
   localparam int LEN_W  = 4;

   // framing symbols
   localparam logic [BYTE_W-1:0] SYM_START  = 8'hEA;
   localparam logic [BYTE_W-1:0] SYM_ESCAPE = 8'hEB;
   localparam logic [BYTE_W-1:0] SYM_END    = 8'hED;

   // controller -> datapath
   typedef struct packed {
      logic clear_count;
      logic store_byte;
      logic start_drain;
      logic load_out;
   } efr_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_start;
      logic is_escape;
      logic is_end;
      logic count_full;
      logic drain_last;
      logic slot_free;
   } efr_sts_type;

endpackage

FILE: hdl/efr_if.sv
interface efr_req_if
   import efr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_rsp_if
   import efr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] payload_byte;
   logic [POS_W-1:0]  byte_position;
   logic [LEN_W-1:0]  frame_length;
   logic              last;

   modport source (output valid, output payload_byte, output byte_position,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input payload_byte, input byte_position,
                   input frame_length, input last, output ready);
endinterface

FILE: hdl/escaped_frame_receiver.sv
// Channel   Role    Payload                                           Handshake
// req_chan  sink    rx_byte[7:0]                                      valid/ready
// rsp_chan  source  payload_byte[7:0] byte_position[3:0]
//                   frame_length[3:0] last                            valid/ready
//
// A received byte is taken every cycle while the receive state is active.
// An end byte hands over to the drain, which loads one stored byte per
// cycle into the output register while the result sink keeps up; input
// is held off until the drain has loaded the frame's last result.
// Synchronous active-high reset clears framing flags, counts and output valid;
// the payload buffer has no reset and is only read below the current count.
// The output register acts as a skid: the last result of a frame may wait
// while the next frame's bytes are already being taken.
module escaped_frame_receiver
   import efr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   efr_req_if.sink    req_chan,
   efr_rsp_if.source  rsp_chan
);

   efr_cmd_type cmd;
   efr_sts_type sts;

   // framing state machine: decides store, restart, abort and drain
   efr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // byte decode, payload buffer, counters and result register
   efr_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .rx_byte       (req_chan.rx_byte),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .payload_byte  (rsp_chan.payload_byte),
      .byte_position (rsp_chan.byte_position),
      .frame_length  (rsp_chan.frame_length),
      .last          (rsp_chan.last)
   );

endmodule

FILE: hdl/efr_ctrl.sv
module efr_ctrl
   import efr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  efr_sts_type sts,
   output efr_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_RECV  = 2'b01,
      S_DRAIN = 2'b10
   } efr_state_type;

   efr_state_type state_ff, state_in;
   logic          in_frame_ff, in_frame_in;
   logic          esc_ff, esc_in;
   logic          accept;

   assign req_ready = (state_ff == S_RECV);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in    = state_ff;
      in_frame_in = in_frame_ff;
      esc_in      = esc_ff;
      cmd         = '0;
      unique case (state_ff)
         S_RECV: begin
            if (accept) begin
               priority if (!in_frame_ff) begin
                  if (sts.is_start) begin
                     in_frame_in     = 1'b1;
                     esc_in          = 1'b0;
                     cmd.clear_count = 1'b1;
                  end
               end else if (esc_ff) begin
                  // only framing symbols may be escaped
                  if ((sts.is_start || sts.is_escape || sts.is_end) && !sts.count_full) begin
                     cmd.store_byte = 1'b1;
                     esc_in         = 1'b0;
                  end else begin
                     in_frame_in     = 1'b0;
                     esc_in          = 1'b0;
                     cmd.clear_count = 1'b1;
                  end
               end else if (sts.is_escape) begin
                  esc_in = 1'b1;
               end else if (sts.is_end) begin
                  in_frame_in     = 1'b0;
                  esc_in          = 1'b0;
                  cmd.start_drain = 1'b1;
                  state_in        = S_DRAIN;
               end else if (sts.is_start) begin
                  cmd.clear_count = 1'b1;
               end else if (!sts.count_full) begin
                  cmd.store_byte = 1'b1;
               end else begin
                  // overflow: drop byte, abort
                  in_frame_in     = 1'b0;
                  esc_in          = 1'b0;
                  cmd.clear_count = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            if (sts.slot_free) begin
               cmd.load_out = 1'b1;
               if (sts.drain_last) begin
                  state_in = S_RECV;
               end
            end
         end
         default: begin
            state_in = S_RECV;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_RECV;
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
      end
   end

`ifndef SYNTHESIS
   a_drain_enters : assert property (@(posedge clock) disable iff (reset)
      cmd.start_drain |=> (state_ff == S_DRAIN))
      else $error("drain not entered after end byte");

   a_drain_leaves : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAIN && sts.slot_free && sts.drain_last) |=> (state_ff == S_RECV))
      else $error("drain did not finish on last result");
`endif

endmodule

FILE: hdl/efr_dpath.sv
module efr_dpath
   import efr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] rx_byte,
   input  efr_cmd_type       cmd,
   output efr_sts_type       sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] payload_byte,
   output logic [POS_W-1:0]  byte_position,
   output logic [LEN_W-1:0]  frame_length,
   output logic              last
);

   logic [BYTE_W-1:0] store_ff [MAX_PAYLOAD];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [LEN_W-1:0]  flen_ff;
   logic              last_ff;
   logic [CNT_W-1:0]  idx_next;

   assign idx_next = idx_ff + CNT_W'(1);

   assign sts.is_start   = (rx_byte == SYM_START);
   assign sts.is_escape  = (rx_byte == SYM_ESCAPE);
   assign sts.is_end     = (rx_byte == SYM_END);
   assign sts.count_full = (count_ff == CNT_W'(MAX_PAYLOAD));
   assign sts.drain_last = (len_ff == '0) || (idx_next == len_ff);
   assign sts.slot_free  = !valid_ff || rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.store_byte) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      len_in = len_ff;
      if (cmd.start_drain) begin
         idx_in = '0;
         len_in = count_ff;
      end else if (cmd.load_out) begin
         idx_in = idx_next;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         len_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         len_ff   <= len_in;
         valid_ff <= valid_in;
      end
   end

   // payload buffer and output register, no reset
   always_ff @(posedge clock) begin
      if (cmd.store_byte) begin
         store_ff[count_ff[IDX_W-1:0]] <= rx_byte;
      end
      if (cmd.load_out) begin
         byte_ff <= (len_ff == '0) ? '0 : store_ff[idx_ff[IDX_W-1:0]];
         pos_ff  <= POS_W'(idx_ff);
         flen_ff <= LEN_W'(len_ff);
         last_ff <= sts.drain_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign payload_byte  = byte_ff;
   assign byte_position = pos_ff;
   assign frame_length  = flen_ff;
   assign last          = last_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("payload count beyond buffer depth");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> sts.slot_free)
      else $error("output register overwritten while held");
`endif

endmodule

FILE: tb/tb_escaped_frame_receiver.sv
`timescale 1ns / 100ps

// Self-checking bench for the escaped frame receiver.
// Every received byte that completes a handshake is fed to a behavioural
// decoder, which queues the payload beats that an end byte releases. The
// monitor pops that queue for every result transaction and compares it
// field by field.
module tb_escaped_frame_receiver;
   import efr_pkg::*;

   localparam int CLK_HALF_NS  = 10;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_BYTES = 420;
   // idling regimes are switched on the number of bytes taken so far
   localparam int PHASE1_AT    = 150;
   localparam int PHASE2_AT    = 300;
   // long result back-pressure, started once this many bytes have gone in
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 300;
   // worst drain is eleven beats; leave plenty of room after the last one
   localparam int DRAIN_CYCLES = 40;
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] payload_byte;
      logic [POS_W-1:0]  byte_position;
      logic [LEN_W-1:0]  frame_length;
      logic              last;
   } payload_beat_type;

   logic clock;
   logic reset;

   efr_req_if req_chan ();
   efr_rsp_if rsp_chan ();

   escaped_frame_receiver u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // bytes still to be offered, and beats still owed by the block
   logic [BYTE_W-1:0] rx_pending[$];
   payload_beat_type  beats_due[$];

   int n_taken;      // received bytes accepted so far
   int n_queued;     // counted stimulus bytes (noise excluded)
   int n_faults;
   int hold_left;    // cycles left in the long result stall
   logic hold_fired;

   // ---------------------------------------------------------------------
   // Behavioural decoder: own copy of the framing state
   // ---------------------------------------------------------------------
   logic              fr_open;
   logic              esc_seen;
   logic [CNT_W-1:0]  stored_cnt;
   logic [BYTE_W-1:0] stored_bytes [MAX_PAYLOAD];

   function automatic logic is_symbol(input logic [BYTE_W-1:0] b);
      return (b == SYM_START) || (b == SYM_ESCAPE) || (b == SYM_END);
   endfunction

   function void drop_frame();
      fr_open    = 1'b0;
      esc_seen   = 1'b0;
      stored_cnt = '0;
   endfunction

   // a byte that would overrun the buffer kills the frame and is lost
   function void keep_byte(input logic [BYTE_W-1:0] b);
      if (stored_cnt >= MAX_PAYLOAD) begin
         drop_frame();
      end else begin
         stored_bytes[stored_cnt] = b;
         stored_cnt = stored_cnt + 1'b1;
         esc_seen   = 1'b0;
      end
   endfunction

   function void release_frame();
      payload_beat_type beat;
      fr_open  = 1'b0;
      esc_seen = 1'b0;
      if (stored_cnt == 0) begin
         // empty frame still yields one beat, all zero but for last
         beat = '{payload_byte: '0, byte_position: '0, frame_length: '0, last: 1'b1};
         beats_due.push_back(beat);
      end else begin
         for (int k = 0; k < stored_cnt; k++) begin
            beat.payload_byte  = stored_bytes[k];
            beat.byte_position = POS_W'(k);
            beat.frame_length  = LEN_W'(stored_cnt);
            beat.last          = (k == stored_cnt - 1);
            beats_due.push_back(beat);
         end
      end
   endfunction

   function void decode_rx_byte(input logic [BYTE_W-1:0] b);
      if (!fr_open) begin
         // outside a frame only a start byte matters
         if (b == SYM_START) begin
            fr_open    = 1'b1;
            esc_seen   = 1'b0;
            stored_cnt = '0;
         end
      end else if (esc_seen) begin
         // only framing symbols may be escaped
         if (is_symbol(b))
            keep_byte(b);
         else
            drop_frame();
      end else if (b == SYM_ESCAPE) begin
         esc_seen = 1'b1;
      end else if (b == SYM_END) begin
         release_frame();
      end else if (b == SYM_START) begin
         stored_cnt = '0;   // restart, frame stays open
      end else begin
         keep_byte(b);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do
         b = BYTE_W'($urandom_range(0, 255));
      while (is_symbol(b));
      return b;
   endfunction

   function void queue_byte(input logic [BYTE_W-1:0] b);
      rx_pending.push_back(b);
      n_queued++;
   endfunction

   // n payload bytes; about one in five is an escaped framing symbol
   function void queue_payload(input int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            pick = $urandom_range(0, 2);
            queue_byte(SYM_ESCAPE);
            queue_byte(pick == 0 ? SYM_START : (pick == 1 ? SYM_ESCAPE : SYM_END));
         end else begin
            queue_byte(plain_byte());
         end
      end
   endfunction

   function void report_fault(input string msg);
      if (n_faults < REPORT_MAX)
         $display("%0t: %s", $realtime, msg);
      n_faults++;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and watchdog
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #(CLK_HALF_NS) clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Long stall on the result side, timed in its own process. The sender
   // keeps offering throughout so the buffer and output skid fill up and
   // the input handshake has to stall.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_fired <= 1'b0;
      end else if (!hold_fired && n_taken >= HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_fired <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Driver: offers the pending bytes; each accepted transaction goes
   // straight into the decoder.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_p
      int idle_pct;
      if (reset) begin
         req_chan.valid <= 1'b0;
         n_taken        <= 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            decode_rx_byte(req_chan.rx_byte);
            n_taken <= n_taken + 1;
         end
         if (hold_left != 0)
            idle_pct = 0;
         else if (n_taken < PHASE1_AT)
            idle_pct = 37;
         else if (n_taken < PHASE2_AT)
            idle_pct = 48;
         else
            idle_pct = 0;
         // only move on once the current offer has been taken
         if (!req_chan.valid || req_chan.ready) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
               req_chan.valid   <= 1'b1;
               req_chan.rx_byte <= rx_pending.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks every result transaction, drives ready
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_p
      payload_beat_type got;
      payload_beat_type want;
      int               idle_pct;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.payload_byte  = rsp_chan.payload_byte;
            got.byte_position = rsp_chan.byte_position;
            got.frame_length  = rsp_chan.frame_length;
            got.last          = rsp_chan.last;
            if (beats_due.size() == 0) begin
               report_fault($sformatf("unexpected beat: byte %02h pos %0d len %0d last %0b",
                  got.payload_byte, got.byte_position, got.frame_length, got.last));
            end else begin
               want = beats_due.pop_front();
               if (got.payload_byte !== want.payload_byte ||
                   got.byte_position !== want.byte_position ||
                   got.frame_length !== want.frame_length ||
                   got.last !== want.last)
                  report_fault($sformatf({"beat mismatch: expected byte %02h pos %0d ",
                     "len %0d last %0b, got byte %02h pos %0d len %0d last %0b"},
                     want.payload_byte, want.byte_position, want.frame_length, want.last,
                     got.payload_byte, got.byte_position, got.frame_length, got.last));
            end
         end
         if (n_taken < PHASE1_AT)
            idle_pct = 48;
         else if (n_taken < PHASE2_AT)
            idle_pct = 37;
         else
            idle_pct = 0;
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      int kind;
      int start_cnt;

      req_chan.valid   = 1'b0;
      req_chan.rx_byte = '0;
      rsp_chan.ready   = 1'b0;
      n_faults   = 0;
      n_queued   = 0;
      fr_open    = 1'b0;
      esc_seen   = 1'b0;
      stored_cnt = '0;

      // directed: stray bytes outside a frame, all bits low and high
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(SYM_END);
      queue_byte(SYM_ESCAPE);
      // empty frame
      queue_byte(SYM_START);
      queue_byte(SYM_END);
      // every escapable symbol stored literally, plus plain extremes
      queue_byte(SYM_START);
      queue_byte(8'h00);
      queue_byte(SYM_ESCAPE);
      queue_byte(SYM_START);
      queue_byte(SYM_ESCAPE);
      queue_byte(SYM_ESCAPE);
      queue_byte(SYM_ESCAPE);
      queue_byte(SYM_END);
      queue_byte(8'hFF);
      queue_byte(SYM_END);
      // bad escape aborts, trailing end byte falls outside a frame
      queue_byte(SYM_START);
      queue_byte(8'h11);
      queue_byte(SYM_ESCAPE);
      queue_byte(8'h55);
      queue_byte(SYM_END);
      // restart inside a frame drops what was stored
      queue_byte(SYM_START);
      queue_byte(8'h12);
      queue_byte(SYM_START);
      queue_byte(8'h56);
      queue_byte(SYM_END);

      // random part, mostly well-formed frames with random content
      start_cnt = n_queued;
      while (n_queued - start_cnt < RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            queue_byte(SYM_START);
            if ($urandom_range(0, 9) == 0) begin
               queue_payload($urandom_range(0, 5));
               queue_byte(SYM_START);
            end
            queue_payload($urandom_range(0, MAX_PAYLOAD));
            queue_byte(SYM_END);
         end else if (kind < 80) begin
            // overflow: too many bytes, end byte then mostly lands outside
            queue_byte(SYM_START);
            queue_payload(MAX_PAYLOAD + $urandom_range(1, 2));
            queue_byte(SYM_END);
         end else if (kind < 90) begin
            // broken escape part way through
            queue_byte(SYM_START);
            queue_payload($urandom_range(0, MAX_PAYLOAD));
            queue_byte(SYM_ESCAPE);
            queue_byte(plain_byte());
            queue_byte(SYM_END);
         end else begin
            // line noise, not counted
            repeat ($urandom_range(1, 3))
               rx_pending.push_back(BYTE_W'($urandom_range(0, 255)));
         end
      end

      // sampled away from the active edge so the checks settle first
      while (rx_pending.size() != 0 || req_chan.valid !== 1'b0 || beats_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (n_faults == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
